/* hdl/ltm_pkg.sv */
package ltm_pkg;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic        [15:0] ground_speed;
    logic        [15:0] altitude;
    logic        [5:0]  satellites;
    logic               have_altitude;
    logic               have_fix;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
  } ltm_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } ltm_rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StSend
  } ltm_state_e;

  // Frame framing bytes.
  localparam logic [7:0] Hdr0Byte  = 8'h24;  // '$'
  localparam logic [7:0] Hdr1Byte  = 8'h54;  // 'T'
  localparam logic [7:0] TypeAByte = 8'h41;  // 'A'
  localparam logic [7:0] TypeGByte = 8'h47;  // 'G'

  // Multiplier constants.
  localparam logic [23:0] LatScale  = 24'd10;
  localparam logic [23:0] AltScale  = 24'd100;
  localparam logic [23:0] SpdScale  = 24'd100;
  localparam logic [22:0] SpdOffset = 23'd50;
  // ceil(2^35 / 3600): exact division by 3600 for any 23-bit dividend.
  localparam logic [23:0] SpdRecip  = 24'd9544372;
  localparam int unsigned SpdShift  = 35;
  localparam logic [23:0] AngScale  = 24'd6008;
  localparam int unsigned AngShift  = 20;

  // Calculation step codes.
  localparam logic [2:0] StepLat    = 3'd0;
  localparam logic [2:0] StepLon    = 3'd1;
  localparam logic [2:0] StepSpdMul = 3'd2;
  localparam logic [2:0] StepSpdDiv = 3'd3;
  localparam logic [2:0] StepAlt    = 3'd4;
  localparam logic [2:0] StepPitch  = 3'd0;
  localparam logic [2:0] StepRoll   = 3'd1;
  localparam logic [2:0] StepYaw    = 3'd2;

  // Byte positions within a frame.
  localparam logic [4:0] PosHdr0    = 5'd0;
  localparam logic [4:0] PosHdr1    = 5'd1;
  localparam logic [4:0] PosType    = 5'd2;
  localparam logic [4:0] PosLastAtt = 5'd9;
  localparam logic [4:0] PosLastGps = 5'd17;

endpackage

/* hdl/ltm_telemetry_frame_encoder.sv */
// Sequence: an accepted request enters the calculation phase on the next cycle; the first
// byte ('$') is sent after the last calculation step, for an attitude or a GPS frame alike.
// Requests are accepted only when idle, after the previous frame's checksum byte. The single
// 32x24 multiplier serves each scaled field (speed twice); bytes follow one per cycle unless stalled.
// Reset: asynchronous, active low; clears the sequencer, byte counter, checksum and
// output valid. Payload registers are not reset.
module ltm_telemetry_frame_encoder
  import ltm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ltm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ltm_rsp_t out_rsp_o
);

  ltm_state_e state_q, state_d;

  ltm_req_t    req_q;
  logic [2:0]  calc_idx_q;
  logic [4:0]  byte_pos_q;
  logic [7:0]  running_xor_q;
  logic [111:0] payload_q;
  logic [22:0] spd_tmp_q;
  logic        out_valid_q;
  ltm_rsp_t    out_q;

  logic        accept;
  logic        emit;
  logic        calc_last;
  logic [4:0]  pos_last;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] prod;
  logic [15:0] ang_raw;
  logic [16:0] ang_mag;
  logic [15:0] ang_deg;
  logic [15:0] ang_out;
  logic [1:0]  fix_code;
  ltm_rsp_t    emit_rsp;
  logic        emit_payload;

  assign accept   = in_valid_i && in_ready_o;
  assign pos_last = req_q.req_type ? PosLastGps : PosLastAtt;
  assign calc_last = req_q.req_type ? (calc_idx_q == StepAlt) : (calc_idx_q == StepYaw);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StCalc;
      end
      StCalc: begin
        if (calc_last) state_d = StSend;
      end
      StSend: begin
        if (emit && emit_rsp.last_byte) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o = (state_q == StIdle);
    emit       = (state_q == StSend) && (!out_valid_q || out_ready_i);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (calc_idx_q)
      StepPitch: ang_raw = req_q.pitch_angle;
      StepRoll:  ang_raw = req_q.roll_angle;
      default:   ang_raw = req_q.yaw_angle;
    endcase
    ang_mag = ang_raw[15] ? (17'h10000 - {1'b0, ang_raw}) : {1'b0, ang_raw};

    if (req_q.req_type) begin
      unique case (calc_idx_q)
        StepLat: begin
          mul_a = req_q.latitude;
          mul_b = LatScale;
        end
        StepLon: begin
          mul_a = req_q.longitude;
          mul_b = LatScale;
        end
        StepSpdMul: begin
          mul_a = {16'd0, req_q.ground_speed};
          mul_b = SpdScale;
        end
        StepSpdDiv: begin
          mul_a = {9'd0, spd_tmp_q};
          mul_b = SpdRecip;
        end
        default: begin
          mul_a = {16'd0, req_q.altitude};
          mul_b = AltScale;
        end
      endcase
    end else begin
      mul_a = {15'd0, ang_mag};
      mul_b = AngScale;
    end
  end

  assign prod     = {24'd0, mul_a} * {32'd0, mul_b};
  assign ang_deg  = prod[AngShift +: 16];
  assign ang_out  = ang_raw[15] ? (16'd0 - ang_deg) : ang_deg;
  assign fix_code = 2'd1 + {1'b0, req_q.have_altitude} + {1'b0, req_q.have_fix};

  // Byte selection while sending.
  always_comb begin
    emit_payload = 1'b0;
    emit_rsp.last_byte = 1'b0;
    priority if (byte_pos_q == PosHdr0) begin
      emit_rsp.frame_byte = Hdr0Byte;
    end else if (byte_pos_q == PosHdr1) begin
      emit_rsp.frame_byte = Hdr1Byte;
    end else if (byte_pos_q == PosType) begin
      emit_rsp.frame_byte = req_q.req_type ? TypeGByte : TypeAByte;
    end else if (byte_pos_q == pos_last) begin
      emit_rsp.frame_byte = running_xor_q;
      emit_rsp.last_byte  = 1'b1;
    end else begin
      emit_rsp.frame_byte = payload_q[7:0];
      emit_payload        = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      calc_idx_q    <= 3'd0;
      byte_pos_q    <= 5'd0;
      running_xor_q <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        calc_idx_q    <= 3'd0;
        byte_pos_q    <= 5'd0;
        running_xor_q <= 8'd0;
      end else if (state_q == StCalc) begin
        calc_idx_q <= calc_idx_q + 3'd1;
      end else if (emit) begin
        byte_pos_q <= emit_rsp.last_byte ? 5'd0 : (byte_pos_q + 5'd1);
        if (emit_payload) running_xor_q <= running_xor_q ^ payload_q[7:0];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    if (emit) out_q <= emit_rsp;
    if (state_q == StCalc) begin
      if (req_q.req_type) begin
        unique case (calc_idx_q)
          StepLat:    payload_q[31:0]  <= prod[31:0];
          StepLon:    payload_q[63:32] <= prod[31:0];
          StepSpdMul: spd_tmp_q        <= prod[22:0] - SpdOffset;
          StepSpdDiv: begin
            payload_q[71:64] <= (req_q.ground_speed == 16'd0) ? 8'd0
                                                               : prod[SpdShift +: 8];
          end
          default: begin
            payload_q[103:72]  <= prod[31:0];
            payload_q[111:104] <= {req_q.satellites, fix_code};
          end
        endcase
      end else begin
        unique case (calc_idx_q)
          StepPitch: payload_q[15:0]  <= ang_out;
          StepRoll:  payload_q[31:16] <= ang_out;
          default:   payload_q[47:32] <= ang_out;
        endcase
      end
    end else if (emit && emit_payload) begin
      payload_q <= {8'd0, payload_q[111:8]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StCalc))
    else $error("accepted request did not start calculation");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSend) |-> (byte_pos_q <= pos_last))
    else $error("byte position ran past the checksum");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_rsp.last_byte) |=> (state_q == StIdle))
    else $error("frame did not end after the checksum byte");

  a_calc_no_pending_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCalc) && out_valid_q) |-> out_q.last_byte)
    else $error("new frame started while a frame byte was still pending");

endmodule
